// ===== hdl/sha_pkg.sv =====
// Package for the SHA-256 nonce search core: constants, types and round functions.
// Depends on nothing; used by every module in hdl.
package sha_pkg;

  localparam int unsigned RegIdxW = 1;
  localparam logic [RegIdxW-1:0] RegSalt = 1'b0;
  localparam logic [RegIdxW-1:0] RegDiff = 1'b1;
  localparam int unsigned CfgW = 32;
  localparam int unsigned DiffW = 6;
  localparam logic [DiffW-1:0] DiffReset = 6'd16;
  localparam int unsigned Rounds = 64;

  typedef logic [31:0] word_t;
  typedef word_t [7:0] state_t;
  typedef word_t [15:0] sched_t;

  localparam word_t [63:0] RoundK = '{
    32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
    32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
    32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
    32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
    32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
    32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
    32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
    32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
    32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
    32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
    32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
    32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
    32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
    32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
    32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
    32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98};

  localparam state_t InitH = '{
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

  localparam word_t PadWord = 32'h80000000;
  localparam word_t LenWord = 32'd64;

  function automatic word_t swap32(input word_t x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One compression round; v[0] is a, v[7] is h.
  function automatic state_t round_f(input state_t v, input word_t k, input word_t w);
    word_t t1, t2;
    state_t r;
    t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
       + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k + w;
    t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
       + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    r[7] = v[6]; r[6] = v[5]; r[5] = v[4]; r[4] = v[3] + t1;
    r[3] = v[2]; r[2] = v[1]; r[1] = v[0]; r[0] = t1 + t2;
    return r;
  endfunction

  // Shift the 16-word schedule window by one, appending the next word.
  function automatic sched_t sched_f(input sched_t w);
    word_t s0, s1;
    sched_t r;
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    for (int i = 0; i < 15; i++) r[i] = w[i+1];
    r[15] = s1 + w[9] + s0 + w[0];
    return r;
  endfunction

endpackage

// ===== hdl/sha_lane.sv =====
// One fully unrolled SHA-256 pipeline: one round per stage, 64 stages plus a final add.
// Depends on sha_pkg.
module sha_lane (
  input  logic         clk_i,
  input  logic         en_i,
  input  sha_pkg::word_t salt_i,
  input  sha_pkg::word_t nonce_i,
  output sha_pkg::state_t digest_o
);

  sha_pkg::state_t v_q [sha_pkg::Rounds+1];
  sha_pkg::sched_t w_q [sha_pkg::Rounds];
  sha_pkg::sched_t w0;

  always_comb begin
    w0 = '0;
    w0[0] = sha_pkg::swap32(salt_i);
    w0[1] = sha_pkg::swap32(nonce_i);
    w0[2] = sha_pkg::PadWord;
    w0[15] = sha_pkg::LenWord;
  end

  // Stage 0 holds the message; stage r+1 holds the state after round r.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q[0] <= sha_pkg::InitH;
      w_q[0] <= w0;
      for (int r = 0; r < sha_pkg::Rounds; r++) begin
        v_q[r+1] <= sha_pkg::round_f(v_q[r], sha_pkg::RoundK[r], w_q[r][0]);
        if (r < sha_pkg::Rounds - 1) w_q[r+1] <= sha_pkg::sched_f(w_q[r]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) digest_o[i] = v_q[sha_pkg::Rounds][i] + sha_pkg::InitH[i];
  end

endmodule

// ===== hdl/sha_merge.sv =====
// Picks the lowest lane whose digest meets the difficulty and registers the word.
// Depends on sha_pkg.
module sha_merge #(
  parameter int unsigned LANES = 4
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [sha_pkg::DiffW-1:0] diff_i,
  input  sha_pkg::word_t  base_i,
  input  sha_pkg::state_t digest_i [LANES],
  output logic            found_o,
  output sha_pkg::word_t  nonce_o,
  output sha_pkg::state_t digest_o
);

  logic            found_d;
  sha_pkg::word_t  nonce_d;
  sha_pkg::state_t digest_d;
  sha_pkg::word_t  mask;

  // Mask of the top bits that must be zero; 32 or more means the whole word.
  always_comb begin
    if (diff_i >= 6'd32) mask = '1;
    else mask = ~({32{1'b1}} >> diff_i[4:0]);
  end

  always_comb begin
    found_d = 1'b0;
    nonce_d = '0;
    digest_d = '0;
    for (int l = LANES - 1; l >= 0; l--) begin
      if ((digest_i[l][0] & mask) == '0) begin
        found_d = 1'b1;
        nonce_d = base_i + 32'(l);
        digest_d = digest_i[l];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      found_o <= found_d;
      nonce_o <= nonce_d;
      digest_o <= digest_d;
    end
  end

endmodule

// ===== hdl/sha256_nonce_search_4lane_core.sv =====
// SHA-256 nonce search: LANES parallel unrolled pipelines and a lowest-lane merge.
// The result word reaches the outputs through the lane pipeline registers and the merge
// output register. Throughput one word per cycle; the whole pipeline advances together
// and freezes while the result is stalled at the output register.
// Reset clears valid bits and sets salt to 0 and difficulty_bits to 16.
// Depends on sha_pkg, sha_lane and sha_merge.
module sha256_nonce_search_4lane_core #(
  parameter int unsigned LANES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [sha_pkg::RegIdxW-1:0] cfg_idx_i,
  input  logic [sha_pkg::CfgW-1:0]    cfg_data_i,
  input  logic        nonce_base_valid_i,
  output logic        nonce_base_stall_o,
  input  logic [31:0] nonce_base_i,
  output logic        result_valid_o,
  input  logic        result_stall_i,
  output logic        found_o,
  output logic [31:0] nonce_o,
  output logic [31:0] digest_w0_o,
  output logic [31:0] digest_w1_o,
  output logic [31:0] digest_w2_o,
  output logic [31:0] digest_w3_o,
  output logic [31:0] digest_w4_o,
  output logic [31:0] digest_w5_o,
  output logic [31:0] digest_w6_o,
  output logic [31:0] digest_w7_o
);

  localparam int unsigned Depth = sha_pkg::Rounds + 2;

  sha_pkg::word_t salt_q;
  logic [sha_pkg::DiffW-1:0] diff_q;
  logic [Depth-1:0] vld_q;
  sha_pkg::word_t base_q [Depth-1];
  logic en;
  sha_pkg::state_t lane_dig [LANES];
  sha_pkg::state_t dig;

  // Advance whenever the output slot is empty or being taken.
  assign en = !vld_q[Depth-1] || !result_stall_i;
  assign nonce_base_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      salt_q <= '0;
      diff_q <= sha_pkg::DiffReset;
      vld_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sha_pkg::RegSalt: salt_q <= cfg_data_i;
          sha_pkg::RegDiff: diff_q <= cfg_data_i[sha_pkg::DiffW-1:0];
          default: ;
        endcase
      end
      if (en) vld_q <= {vld_q[Depth-2:0], nonce_base_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      base_q[0] <= nonce_base_i;
      for (int s = 1; s < Depth - 1; s++) base_q[s] <= base_q[s-1];
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    sha_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (en),
      .salt_i  (salt_q),
      .nonce_i (nonce_base_i + 32'(l)),
      .digest_o(lane_dig[l])
    );
  end

  sha_merge #(.LANES(LANES)) u_merge (
    .clk_i   (clk_i),
    .en_i    (en),
    .diff_i  (diff_q),
    .base_i  (base_q[Depth-2]),
    .digest_i(lane_dig),
    .found_o (found_o),
    .nonce_o (nonce_o),
    .digest_o(dig)
  );

  assign result_valid_o = vld_q[Depth-1];
  assign digest_w0_o = dig[0];
  assign digest_w1_o = dig[1];
  assign digest_w2_o = dig[2];
  assign digest_w3_o = dig[3];
  assign digest_w4_o = dig[4];
  assign digest_w5_o = dig[5];
  assign digest_w6_o = dig[6];
  assign digest_w7_o = dig[7];

endmodule

// ===== bench/tb_sha256_nonce_search_4lane_core.sv =====
// Testbench for sha256_nonce_search_4lane_core: drives nonce base words, predicts each
// four-lane search with its own SHA-256 and checks every result word in order.
// Depends on sha_pkg and the core in hdl.
module tb_sha256_nonce_search_4lane_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumLanes = 4;
  localparam int unsigned CycleLimit = 1500000;

  typedef struct {
    logic        found;
    logic [31:0] nonce;
    logic [31:0] dig [8];
  } search_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [sha_pkg::RegIdxW-1:0] cfg_idx_i = sha_pkg::RegSalt;
  logic [sha_pkg::CfgW-1:0] cfg_data_i = '0;
  logic nonce_base_valid_i = 1'b0;
  logic nonce_base_stall_o;
  logic [31:0] nonce_base_i = '0;
  logic result_valid_o;
  logic result_stall_i = 1'b0;
  logic found_o;
  logic [31:0] nonce_o;
  logic [31:0] digest_w0_o, digest_w1_o, digest_w2_o, digest_w3_o;
  logic [31:0] digest_w4_o, digest_w5_o, digest_w6_o, digest_w7_o;

  sha256_nonce_search_4lane_core #(.LANES(NumLanes)) DUT (.*);

  always #5 clk_i = ~clk_i;

  logic [31:0] cur_salt = 32'h0;
  logic [5:0]  cur_diff = 6'd16;
  logic [31:0] nonce_queue [$];
  search_res_t expected_res [$];
  int unsigned errors = 0;
  int unsigned n_results = 0;
  int unsigned n_found = 0;
  int unsigned n_words = 0;
  int unsigned cycles = 0;
  bit no_idle = 1'b0;

  const logic [31:0] rk [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
  const logic [31:0] h0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] byte_rev(logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  // One padded block: salt word, nonce word, pad bit, length 64.
  function automatic void hash_nonce(logic [31:0] salt, logic [31:0] n,
                                     output logic [31:0] dig [8]);
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 64; i++) w[i] = '0;
    w[0] = byte_rev(salt);
    w[1] = byte_rev(n);
    w[2] = 32'h80000000;
    w[15] = 32'd64;
    for (int i = 16; i < 64; i++)
      w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    for (int i = 0; i < 8; i++) v[i] = h0[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + rk[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) dig[i] = h0[i] + v[i];
  endfunction

  function automatic search_res_t search_lanes(logic [31:0] base);
    search_res_t r;
    logic [31:0] dig [8];
    logic [31:0] n;
    bit hit;
    r.found = 1'b0;
    r.nonce = '0;
    for (int j = 0; j < 8; j++) r.dig[j] = '0;
    for (int lane = 0; lane < NumLanes; lane++) begin
      n = base + lane;
      hash_nonce(cur_salt, n, dig);
      // Zero difficulty always hits; 32 and above needs the whole word zero.
      if (cur_diff == 0) hit = 1'b1;
      else if (cur_diff >= 32) hit = (dig[0] == 0);
      else hit = ((dig[0] >> (32 - cur_diff)) == 0);
      if (hit) begin
        r.found = 1'b1;
        r.nonce = n;
        for (int j = 0; j < 8; j++) r.dig[j] = dig[j];
        break;
      end
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: offers queued nonce base words, holding each while stalled.
  int gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni && (!nonce_base_valid_i || !nonce_base_stall_o)) begin
      if (nonce_base_valid_i) begin
        expected_res.push_back(search_lanes(nonce_base_i));
        n_words++;
      end
      if (gap_left > 0) begin
        gap_left--;
        nonce_base_valid_i <= 1'b0;
      end else if (nonce_queue.size() > 0) begin
        nonce_base_valid_i <= 1'b1;
        nonce_base_i <= nonce_queue.pop_front();
        gap_left = pick_gap();
      end else begin
        nonce_base_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: random back-pressure, one long hold, in-order comparison.
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk_i) begin
    search_res_t e;
    logic [31:0] act [8];
    if (rst_ni) begin
      if (result_valid_o && !result_stall_i) begin
        act = '{digest_w0_o, digest_w1_o, digest_w2_o, digest_w3_o,
                digest_w4_o, digest_w5_o, digest_w6_o, digest_w7_o};
        n_results++;
        if (found_o) n_found++;
        if (expected_res.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          e = expected_res.pop_front();
          if (found_o !== e.found) begin
            $error("found: expected %0d, actual %0d", e.found, found_o);
            errors++;
          end
          if (nonce_o !== e.nonce) begin
            $error("nonce: expected %h, actual %h", e.nonce, nonce_o);
            errors++;
          end
          for (int j = 0; j < 8; j++)
            if (act[j] !== e.dig[j]) begin
              $error("digest_w%0d: expected %h, actual %h", j, e.dig[j], act[j]);
              errors++;
            end
        end
      end
      if (!hold_done && n_results == 300) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall_i <= 1'b1;
      end else if (no_idle) begin
        result_stall_i <= 1'b0;
      end else begin
        result_stall_i <= ($urandom_range(0, 99) < 25) ||
                          ($urandom_range(0, 199) == 0);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_sha256_nonce_search_4lane_core NOT OK");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(negedge clk_i);
    while (nonce_queue.size() != 0 || nonce_base_valid_i || expected_res.size() != 0);
  endtask

  task automatic write_reg(logic [sha_pkg::RegIdxW-1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == sha_pkg::RegSalt) cur_salt = val;
    else cur_diff = val[5:0];
  endtask

  task automatic run_phase(logic [31:0] salt, logic [5:0] diff, int count);
    wait_idle();
    write_reg(sha_pkg::RegSalt, salt);
    write_reg(sha_pkg::RegDiff, {26'b0, diff});
    for (int i = 0; i < count; i++) nonce_queue.push_back($urandom());
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed words at reset settings: extremes and nonce wrap.
    nonce_queue = '{32'h0, 32'hffffffff, 32'hfffffffe, 32'hfffffffd, 32'h7fffffff,
                    32'h80000000, 32'haaaaaaaa, 32'h55555555};
    wait_idle();
    write_reg(sha_pkg::RegDiff, 32'd0);
    nonce_queue = '{32'h0, 32'hffffffff, 32'hfffffffd, 32'h12345678};
    wait_idle();
    write_reg(sha_pkg::RegSalt, 32'hffffffff);
    write_reg(sha_pkg::RegDiff, 32'd1);
    nonce_queue = '{32'hfffffffe, 32'h0, 32'hffffffff, 32'hdeadbeef};
    run_phase($urandom(), 6'd2, 200);
    run_phase($urandom(), 6'd4, 250);
    no_idle = 1'b1;
    run_phase(32'h0, 6'd1, 150);
    wait_idle();
    no_idle = 1'b0;
    run_phase($urandom(), 6'd3, 200);
    run_phase(32'hffffffff, 6'd32, 150);
    run_phase($urandom(), 6'd63, 100);
    run_phase($urandom(), 6'd8, 200);
    run_phase($urandom(), 6'($urandom_range(0, 6)), 150);
    run_phase($urandom(), 6'd0, 100);
    run_phase($urandom(), 6'd16, 100);
    wait_idle();
    repeat (100) @(posedge clk_i);
    $display("Checked %0d result words from %0d nonce groups, %0d with a hit,",
             n_results, n_words, n_found);
    $display("over difficulties 0 to 63, several salts and one long output hold.");
    if (errors == 0 && expected_res.size() == 0) begin
      $display("tb_sha256_nonce_search_4lane_core OK");
    end else begin
      $display("tb_sha256_nonce_search_4lane_core NOT OK");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hdl/sha_pkg.sv
hdl/sha_lane.sv
hdl/sha_merge.sv
hdl/sha256_nonce_search_4lane_core.sv
bench/tb_sha256_nonce_search_4lane_core.sv
